### src/tte_pkg.sv
// Shared types and codes for the timer table engine.
package tte_pkg;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FIRED    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIRE,
        S_EMIT
    } state_t;

    localparam int MAX_FIRE = 16;

endpackage

### src/timer_table_engine.sv
// Timer table engine top level: slot table, scan sequencer and result register.
//
// Usage:
//   Input channel (in_valid/in_stall) carries action, delay_ms, repeat_flag
//   and timer_id. Output channel (out_valid/out_stall) carries status,
//   result_id, alive_flag, periodic_flag and last.
//   One sequencer visits the slots one per cycle through a single compare
//   unit. Add, cancel and query give one result after the item is taken
//   and one scan of the table is done.
//   A tick runs one scan, then for each fired timer a fire step, a new scan,
//   a step to settle the last flag and the hand-out of the result. Up to 16
//   timers fire per tick. The input side stalls while an item is in work or
//   a result waits; the next item can be taken in the cycle after the final
//   result leaves. A stalled output freezes the sequencer with the result
//   held unchanged. Reset clears all valid bits, the time and the id
//   counter; no clearing pass is needed. A tick that fires nothing gives no
//   result.
module timer_table_engine
    import tte_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_WIDTH = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] delay_ms,
    input  logic        repeat_flag,
    input  logic [15:0] timer_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] result_id,
    output logic        alive_flag,
    output logic        periodic_flag,
    output logic        last
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int FW = $clog2(MAX_FIRE + 1);

    // slot storage
    logic [NUM_TIMERS-1:0] valid_reg;
    logic [NUM_TIMERS-1:0] fired_reg;
    logic [15:0]           ident_mem    [NUM_TIMERS];
    logic [TIME_WIDTH-1:0] expiry_mem   [NUM_TIMERS];
    logic [31:0]           interval_mem [NUM_TIMERS];
    logic                  periodic_mem [NUM_TIMERS];

    state_t                state_reg, state_next;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [15:0]           nid_reg;
    logic [CW-1:0]         cnt_reg;
    logic [FW-1:0]         nfire_reg;
    action_t               act_reg;
    logic [31:0]           delay_reg;
    logic                  rep_reg;
    logic [15:0]           tid_reg;
    logic                  found_reg;
    logic [IW-1:0]         best_reg;
    logic [TIME_WIDTH-1:0] best_exp_reg;

    logic [1:0]  st_reg;
    logic [15:0] rid_reg;
    logic        alive_reg, per_reg, last_reg, ov_reg;
    logic        pend_reg;

    logic [IW-1:0] idx;
    logic          scan_done;
    logic          hit;
    logic          accept;
    logic          fire_done;
    logic          fire_go;

    assign idx       = cnt_reg[IW-1:0];
    assign scan_done = (cnt_reg == CW'(NUM_TIMERS));
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || ov_reg;

    // burst ends when the scan found nothing or the fire cap is reached
    assign fire_done = !found_reg || (nfire_reg == FW'(MAX_FIRE));
    assign fire_go   = !fire_done && !pend_reg && !ov_reg;

    // per-slot match of the shared compare unit
    always_comb
    begin
        hit = 1'b0;
        if (!scan_done)
        begin
            case (act_reg)
                ACT_ADD:  hit = !valid_reg[idx] && !found_reg;
                ACT_TICK: hit = valid_reg[idx] && !fired_reg[idx]
                                && (expiry_mem[idx] <= time_reg)
                                && (!found_reg || expiry_mem[idx] < best_exp_reg);
                default:  hit = valid_reg[idx] && !found_reg
                                && (ident_mem[idx] == tid_reg);
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_SCAN;
            S_SCAN: if (scan_done) state_next = (act_reg == ACT_TICK) ? S_FIRE : S_EMIT;
            S_FIRE:
            begin
                if (fire_done)
                    state_next = S_IDLE;
                else if (fire_go)
                    state_next = S_SCAN;
            end
            S_EMIT: if (!ov_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // control and table update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fired_reg <= '0;
            time_reg  <= '0;
            nid_reg   <= '0;
            cnt_reg   <= '0;
            nfire_reg <= '0;
            found_reg <= 1'b0;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        nfire_reg <= '0;
                        fired_reg <= '0;
                        if (action_t'(action) == ACT_TICK)
                            time_reg <= time_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (!scan_done)
                        cnt_reg <= cnt_reg + 1'b1;
                    if (hit)
                        found_reg <= 1'b1;
                end
                S_FIRE:
                begin
                    // settle the held result once the next scan is known
                    if (pend_reg)
                        pend_reg <= 1'b0;
                    else if (fire_go)
                    begin
                        ov_reg    <= 1'b1;
                        pend_reg  <= 1'b1;
                        fired_reg[best_reg] <= 1'b1;
                        if (!periodic_mem[best_reg])
                            valid_reg[best_reg] <= 1'b0;
                        nfire_reg <= nfire_reg + 1'b1;
                        found_reg <= 1'b0;
                        cnt_reg   <= '0;
                    end
                end
                S_EMIT:
                begin
                    if (!ov_reg)
                    begin
                        ov_reg <= 1'b1;
                        if (act_reg == ACT_ADD && found_reg)
                        begin
                            valid_reg[best_reg] <= 1'b1;
                            nid_reg <= nid_reg + 1'b1;
                        end
                        if (act_reg == ACT_CANCEL && found_reg)
                            valid_reg[best_reg] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action_t'(action);
            delay_reg <= delay_ms;
            rep_reg   <= repeat_flag;
            tid_reg   <= timer_id;
        end
        if (state_reg == S_SCAN && hit)
        begin
            best_reg     <= idx;
            best_exp_reg <= expiry_mem[idx];
        end
        if (state_reg == S_FIRE && fire_go)
        begin
            if (periodic_mem[best_reg])
                expiry_mem[best_reg] <= best_exp_reg + TIME_WIDTH'(interval_mem[best_reg]);
            st_reg    <= ST_FIRED;
            rid_reg   <= ident_mem[best_reg];
            alive_reg <= 1'b0;
            per_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        // held fired result is last when nothing more will fire
        if (state_reg == S_FIRE && pend_reg)
            last_reg <= fire_done;
        if (state_reg == S_EMIT && !ov_reg)
        begin
            last_reg <= 1'b1;
            case (act_reg)
                ACT_ADD:
                begin
                    alive_reg <= 1'b0;
                    per_reg   <= 1'b0;
                    st_reg    <= found_reg ? ST_OK : ST_FULL;
                    rid_reg   <= found_reg ? nid_reg : 16'd0;
                    if (found_reg)
                    begin
                        ident_mem[best_reg]    <= nid_reg;
                        expiry_mem[best_reg]   <= time_reg + TIME_WIDTH'(delay_reg);
                        interval_mem[best_reg] <= delay_reg;
                        periodic_mem[best_reg] <= rep_reg;
                    end
                end
                ACT_QUERY:
                begin
                    st_reg    <= found_reg ? ST_OK : ST_NOTFOUND;
                    rid_reg   <= tid_reg;
                    alive_reg <= found_reg;
                    per_reg   <= found_reg && periodic_mem[best_reg];
                end
                default:
                begin
                    st_reg    <= found_reg ? ST_OK : ST_NOTFOUND;
                    rid_reg   <= tid_reg;
                    alive_reg <= 1'b0;
                    per_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid     = ov_reg && !pend_reg;
    assign status        = st_reg;
    assign result_id     = rid_reg;
    assign alive_flag    = alive_reg;
    assign periodic_flag = per_reg;
    assign last          = last_reg;

    // checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("accept while busy");
    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        nfire_reg <= FW'(MAX_FIRE)) else $error("too many fired");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(NUM_TIMERS)) else $error("scan counter out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)
                                      && $stable(result_id) && $stable(last)))
        else $error("stalled result changed");

endmodule
